// ===== rtl/core/pmdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmdc_pkg: shared types and constants for the page-mode DRAM controller
// Holds the operation and command codes, the controller states, and the
// command and status groups that pass between the controller and datapath.
// ----------------------------------------------------------------------------
package pmdc_pkg;

  // Refresh debt saturates at this limit, and never above the counter width.
  localparam int DEBT_LIMIT = 31;
  localparam int DEBT_W     = 5;
  localparam logic [DEBT_W-1:0] DEBT_CAP =
    (DEBT_LIMIT < 31) ? DEBT_W'(DEBT_LIMIT) : DEBT_W'(31);

  // Configuration port.
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_REFRESH_INTERVAL = 2'd0;
  localparam logic [15:0] REFRESH_INTERVAL_RESET = 16'd2000;

  // Input operation codes.
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_END    = 3'd3,
    OP_NIBBLE = 3'd4
  } op_t;

  // DRAM command codes on the result channel.
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_REFRESH   = 3'd1,
    CMD_ACTIVATE  = 3'd2,
    CMD_READ      = 3'd3,
    CMD_WRITE     = 3'd4,
    CMD_PRECHARGE = 3'd5
  } cmd_t;

  // Kinds of result the datapath can load into its output register.
  typedef enum logic [2:0] {
    RK_REFRESH_TICK,
    RK_REFRESH_DEBT,
    RK_PRECHARGE,
    RK_ACTIVATE,
    RK_READ_HI,
    RK_READ_LO,
    RK_WRITE_HI,
    RK_WRITE_LO
  } result_kind_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PRECHARGE,
    S_ACTIVATE,
    S_COLUMN_HI,
    S_COLUMN_LO,
    S_REFRESH,
    S_EMIT,
    S_READ_BYTE
  } state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic         accept;
    logic         emit;
    result_kind_t kind;
    logic         byte_done;
    logic         last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       out_free;
    logic       fire;
    logic       busy;
    logic       page_open;
    logic       row_hit;
    logic [1:0] read_phase;
    logic       debt_zero;
    logic       debt_one;
  } dp_status_t;

endpackage

// ===== rtl/core/pmdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmdc_ctrl: sequencing state machine of the page-mode DRAM controller
// Accepts one item at a time and steps through the DRAM commands it causes,
// one result per cycle whenever the output register is free.
// ----------------------------------------------------------------------------
module pmdc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             opcode,
  input  pmdc_pkg::dp_status_t   status,
  output pmdc_pkg::ctrl_cmd_t    cmd
);
  import pmdc_pkg::*;

  state_t       state;
  state_t       state_next;
  op_t          op_q;
  op_t          op_next;
  result_kind_t kind_q;
  result_kind_t kind_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      op_q   <= OP_TICK;
      kind_q <= RK_REFRESH_TICK;
    end else begin
      state  <= state_next;
      op_q   <= op_next;
      kind_q <= kind_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    op_next    = op_q;
    kind_next  = kind_q;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          op_next    = op_t'(opcode);
          unique case (op_t'(opcode))
            OP_TICK: begin
              if (status.fire && !status.busy) begin
                kind_next  = RK_REFRESH_TICK;
                state_next = S_EMIT;
              end
            end
            OP_READ, OP_WRITE: begin
              if (status.page_open && !status.row_hit) begin
                state_next = S_PRECHARGE;
              end else if (!status.page_open) begin
                state_next = S_ACTIVATE;
              end else begin
                state_next = S_COLUMN_HI;
              end
            end
            OP_END: begin
              if (status.page_open) begin
                state_next = S_PRECHARGE;
              end else if (!status.debt_zero) begin
                state_next = S_REFRESH;
              end
            end
            OP_NIBBLE: begin
              if (status.read_phase == 2'd1) begin
                kind_next  = RK_READ_LO;
                state_next = S_EMIT;
              end else if (status.read_phase == 2'd2) begin
                state_next = S_READ_BYTE;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_PRECHARGE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = RK_PRECHARGE;
          if (op_q == OP_END) begin
            cmd.last   = status.debt_zero;
            state_next = status.debt_zero ? S_IDLE : S_REFRESH;
          end else begin
            state_next = S_ACTIVATE;
          end
        end
      end
      S_ACTIVATE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = RK_ACTIVATE;
          state_next = S_COLUMN_HI;
        end
      end
      S_COLUMN_HI: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (op_q == OP_READ) begin
            cmd.kind   = RK_READ_HI;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.kind   = RK_WRITE_HI;
            state_next = S_COLUMN_LO;
          end
        end
      end
      S_COLUMN_LO: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = RK_WRITE_LO;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REFRESH: begin
        // One refresh per unit of debt; the datapath counts the debt down.
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = RK_REFRESH_DEBT;
          cmd.last = status.debt_one;
          if (status.debt_one) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = kind_q;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ_BYTE: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.byte_done = 1'b1;
          cmd.last      = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // A result is loaded only when the output register can take it.
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result loaded while output register is occupied");

  // The low write column cycle belongs only to a write byte.
  a_column_lo_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_COLUMN_LO) |-> (op_q == OP_WRITE))
    else $error("low write column cycle outside a write byte");

  // The final result of an item returns the controller to idle.
  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == S_IDLE))
    else $error("controller busy after the final result of an item");
`endif

endmodule

// ===== rtl/core/pmdc_datapath.sv =====
// ----------------------------------------------------------------------------
// pmdc_datapath: state, refresh timer and result register of the controller
// Holds page and read tracking, the refresh interval counter with its debt,
// the captured item fields, and the output register of the result channel.
// ----------------------------------------------------------------------------
module pmdc_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  pmdc_pkg::ctrl_cmd_t    cmd,
  output pmdc_pkg::dp_status_t   status,
  input  logic [15:0]            refresh_interval,
  input  logic [2:0]             opcode,
  input  logic [16:0]            byte_address,
  input  logic [7:0]             write_data,
  input  logic [3:0]             nibble_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             command,
  output logic [8:0]             pin_address,
  output logic [3:0]             write_nibble,
  output logic [7:0]             read_data,
  output logic                   read_valid,
  output logic                   debt_overflow,
  output logic                   last
);
  import pmdc_pkg::*;

  // Control state.
  logic              busy;
  logic              page_open;
  logic [8:0]        open_row;
  logic [DEBT_W-1:0] refresh_debt;
  logic              overflow_flag;
  logic [15:0]       tick_count;
  logic [1:0]        read_phase;
  logic [3:0]        high_nibble;
  logic [7:0]        pending_column;

  // Captured item fields.
  logic [8:0] row_q;
  logic [7:0] col_q;
  logic [7:0] wdata_q;
  logic [3:0] nib_q;

  logic [15:0]       tick_inc;
  logic              fire;
  logic [DEBT_W-1:0] debt_inc;
  logic              out_take;

  // Refresh interval check; an interval of zero means a full counter wrap.
  assign tick_inc = tick_count + 16'd1;
  assign fire     = (refresh_interval == 16'd0) ? (tick_inc == 16'd0)
                                                : (tick_inc >= refresh_interval);
  assign debt_inc = (refresh_debt < DEBT_CAP) ? refresh_debt + DEBT_W'(1)
                                              : refresh_debt;

  assign out_take = out_valid && !out_stall;

  // Status toward the controller.
  always_comb begin
    status.out_free   = !out_valid || !out_stall;
    status.fire       = fire;
    status.busy       = busy;
    status.page_open  = page_open;
    status.row_hit    = (open_row == byte_address[16:8]);
    status.read_phase = read_phase;
    status.debt_zero  = (refresh_debt == '0);
    status.debt_one   = (refresh_debt == DEBT_W'(1));
  end

  // Control state updates at item transfer and at each loaded result.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      page_open      <= 1'b0;
      open_row       <= '0;
      refresh_debt   <= '0;
      overflow_flag  <= 1'b0;
      tick_count     <= '0;
      read_phase     <= 2'd0;
      high_nibble    <= '0;
      pending_column <= '0;
    end else if (cmd.accept) begin
      unique case (op_t'(opcode))
        OP_TICK: begin
          if (fire) begin
            tick_count <= '0;
            if (busy) begin
              refresh_debt <= debt_inc;
              if (debt_inc >= DEBT_CAP) begin
                overflow_flag <= 1'b1;
              end
            end
          end else begin
            tick_count <= tick_inc;
          end
        end
        OP_READ: begin
          busy           <= 1'b1;
          read_phase     <= 2'd1;
          pending_column <= byte_address[7:0];
        end
        OP_WRITE: begin
          busy       <= 1'b1;
          read_phase <= 2'd0;
        end
        OP_END: begin
          busy       <= 1'b0;
          read_phase <= 2'd0;
        end
        OP_NIBBLE: begin
          if (read_phase == 2'd1) begin
            high_nibble <= nibble_in;
            read_phase  <= 2'd2;
          end else if (read_phase == 2'd2) begin
            read_phase <= 2'd0;
          end
        end
        default: begin
          busy <= busy;
        end
      endcase
    end else if (cmd.emit && !cmd.byte_done) begin
      unique case (cmd.kind)
        RK_PRECHARGE: page_open <= 1'b0;
        RK_ACTIVATE: begin
          page_open <= 1'b1;
          open_row  <= row_q;
        end
        RK_REFRESH_DEBT: refresh_debt <= refresh_debt - DEBT_W'(1);
        default: page_open <= page_open;
      endcase
    end
  end

  // Item field capture.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_q   <= byte_address[16:8];
      col_q   <= byte_address[7:0];
      wdata_q <= write_data;
      nib_q   <= nibble_in;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload, formed from the result kind.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      debt_overflow <= overflow_flag;
      last          <= cmd.last;
      write_nibble  <= 4'd0;
      read_data     <= 8'd0;
      read_valid    <= 1'b0;
      pin_address   <= 9'd0;
      if (cmd.byte_done) begin
        command    <= CMD_NONE;
        read_data  <= {high_nibble, nib_q};
        read_valid <= 1'b1;
      end else begin
        unique case (cmd.kind)
          RK_REFRESH_TICK, RK_REFRESH_DEBT: begin
            command <= CMD_REFRESH;
          end
          RK_PRECHARGE: begin
            command     <= CMD_PRECHARGE;
            pin_address <= open_row;
          end
          RK_ACTIVATE: begin
            command     <= CMD_ACTIVATE;
            pin_address <= row_q;
          end
          RK_READ_HI: begin
            command     <= CMD_READ;
            pin_address <= {col_q, 1'b0};
          end
          RK_READ_LO: begin
            command     <= CMD_READ;
            pin_address <= {pending_column, 1'b1};
          end
          RK_WRITE_HI: begin
            command      <= CMD_WRITE;
            pin_address  <= {col_q, 1'b0};
            write_nibble <= wdata_q[7:4];
          end
          RK_WRITE_LO: begin
            command      <= CMD_WRITE;
            pin_address  <= {col_q, 1'b1};
            write_nibble <= wdata_q[3:0];
          end
          default: begin
            command <= CMD_NONE;
          end
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The refresh debt never exceeds its cap.
  a_debt_capped: assert property (@(posedge clk) disable iff (rst)
    refresh_debt <= DEBT_CAP)
    else $error("refresh debt above its cap");

  // Debt grows only from a tick taken while a transfer is busy.
  a_debt_only_busy: assert property (@(posedge clk) disable iff (rst)
    (refresh_debt > $past(refresh_debt)) |-> $past(busy))
    else $error("refresh debt grew while not busy");

  // A row activate opens the page on the captured row.
  a_activate_opens: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !cmd.byte_done && cmd.kind == RK_ACTIVATE)
      |=> (page_open && open_row == $past(row_q)))
    else $error("row activate did not open the page");
`endif

endmodule

// ===== rtl/core/page_mode_dram_controller_top.sv =====
// ----------------------------------------------------------------------------
// page_mode_dram_controller_top: fast-page-mode DRAM command controller
// Input items carry clock ticks, byte reads and writes, end of transfer and
// returned read nibbles. Each item causes zero or more DRAM command results.
// The input channel transfers an item when in_valid is high and in_stall is
// low; the output channel transfers a result when out_valid is high and
// out_stall is low, with last set on the final result of an item.
// Timing: an item is taken when the controller is idle, and its results follow
// one per cycle through a single output register whenever it is free
// (a read to a closed page gives two results, a row miss three, an end of
// transfer with full debt up to one precharge and 31 refreshes). The
// controller state machine, which loads one result a cycle, sets this rate.
// Items with no result (plain ticks, stray nibbles, unused opcodes) leave the
// controller idle. A stall on the output holds the pending result and sequence.
// Reset clears the page, read tracking, refresh timer and debt, and sets the
// refresh interval to 2000 ticks. The interval register lies at address 0
// of the APB-style port and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module page_mode_dram_controller_top (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmdc_pkg::PADDR_W-1:0]  paddr,
  input  logic [pmdc_pkg::PDATA_W-1:0]  pwdata,
  output logic [pmdc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    opcode,
  input  logic [16:0]                   byte_address,
  input  logic [7:0]                    write_data,
  input  logic [3:0]                    nibble_in,
  // Output channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    command,
  output logic [8:0]                    pin_address,
  output logic [3:0]                    write_nibble,
  output logic [7:0]                    read_data,
  output logic                          read_valid,
  output logic                          debt_overflow,
  output logic                          last
);
  import pmdc_pkg::*;

  logic        [15:0] refresh_interval;
  logic               cfg_write;
  ctrl_cmd_t          cmd;
  dp_status_t         status;

  // Configuration register write and read-back.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_interval <= REFRESH_INTERVAL_RESET;
    end else if (cfg_write && paddr == ADDR_REFRESH_INTERVAL) begin
      refresh_interval <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr == ADDR_REFRESH_INTERVAL) begin
      prdata = {{(PDATA_W-16){1'b0}}, refresh_interval};
    end else begin
      prdata = '0;
    end
  end

  // Sequencing state machine.
  pmdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .status   (status),
    .cmd      (cmd)
  );

  // State, refresh timer and result register.
  pmdc_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .refresh_interval (refresh_interval),
    .opcode           (opcode),
    .byte_address     (byte_address),
    .write_data       (write_data),
    .nibble_in        (nibble_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .command          (command),
    .pin_address      (pin_address),
    .write_nibble     (write_nibble),
    .read_data        (read_data),
    .read_valid       (read_valid),
    .debt_overflow    (debt_overflow),
    .last             (last)
  );

endmodule
